// File: hw/rtl/ssps_pkg.sv
// Shared types and constants of the swerve steering PI servo.
// Used by ssps_ctrl, ssps_dp and swerve_steer_pi_servo; depends on nothing.
package ssps_pkg;

  localparam int AFB        = 6;
  localparam int ASC        = 1 << AFB;

  localparam int CMD_W      = 1;
  localparam int TGT_W      = 16;
  localparam int CUR_W      = 15;
  localparam int TIME_W     = 32;
  localparam int PULSE_W    = 11;
  localparam int ERR_W      = 15;
  localparam int PI_W       = 16;
  localparam int TOL_W      = 8;
  localparam int GAIN_W     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEG_W      = 9;
  localparam int WRAP_W     = TGT_W + 1;
  localparam int AERR_W     = 14;
  localparam int DT_W       = 9;
  localparam int ISUM_W     = 24;
  localparam int PROD_W     = ISUM_W + 1;
  localparam int KP1K_W     = 26;
  localparam int P1_W       = KP1K_W + ERR_W + 1;
  localparam int P2_W       = GAIN_W + ISUM_W;
  localparam int MAG_W      = P1_W - 1;
  localparam int QN_W       = 22;
  localparam int RECIP_W    = 23;
  localparam int QP_W       = QN_W + RECIP_W;
  localparam int MINP_W     = 39;
  localparam int MIN_W      = 15;
  localparam int CNT_W      = 3;

  localparam int TURN_FULL  = 360 * ASC;
  localparam int TURN_HALF  = 180 * ASC;
  localparam int FLIP_LIM   = 90 * ASC;
  localparam int INT_WIN    = 70 * ASC;
  localparam int INT_LIM    = 100000 * ASC;
  localparam int EFF_LIM    = 450 * ASC;
  localparam int EFF_MIN    = 70 * ASC;
  localparam int EFF_MAX    = 420 * ASC;
  localparam int WRAP_MOD   = 360;
  localparam int WRAP_BIAS  = 92 * WRAP_MOD;
  localparam int WRAP_STEPS = 8;
  localparam int DT_MAX     = 500;
  localparam int KP_SCALE   = 1000;
  localparam int DIVISOR    = 256000;
  localparam int DIV_HALF   = DIVISOR / 2;
  localparam int DIV_SH     = 11;
  localparam int DIV_ODD    = DIVISOR >> DIV_SH;
  localparam int QN_LIM     = (EFF_LIM + 1) * DIV_ODD;
  localparam int RECIP_SH   = 29;
  localparam int RECIP      = ((1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
  localparam int MIN_SH     = 24;
  localparam int MIN_MUL    = 35 * 932068;
  localparam int PULSE_LO   = 1000;
  localparam int PULSE_HI   = 2000;

  localparam logic [PULSE_W-1:0]   NEUTRAL_RST = 11'd1500;
  localparam logic [TOL_W-1:0]     TOL_RST     = 8'd5;
  localparam logic [GAIN_W-1:0]    KP_RST      = 16'd1024;
  localparam logic signed [GAIN_W-1:0] KI_RST  = -16'sd154;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEUTRAL = 2'd0,
    REG_TOL     = 2'd1,
    REG_KP      = 2'd2,
    REG_KI      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_ERR,
    ST_FLIP,
    ST_MULA,
    ST_INTEG,
    ST_MULB,
    ST_SUM,
    ST_DIV,
    ST_POST1,
    ST_POST2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       wrap;
    logic [2:0] wrap_sh;
    logic       err;
    logic       flip;
    logic       mula;
    logic       integ;
    logic       mulb;
    logic       sum;
    logic       div;
    logic       post1;
    logic       post2;
    logic       deliver;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// File: hw/rtl/swerve_steer_pi_servo.sv
// Top level of the swerve steering PI servo: configuration registers and wiring.
// Depends on ssps_pkg, ssps_ctrl and ssps_dp.
//
//   channel | handshake                 | payload
//   in_     | in_valid / in_stall       | command, target_angle, current_angle, time_ms
//   out_    | out_valid / out_stall     | pulse_us, reversed, in_tolerance, angle_error,
//           |                           | pi_effort
//   cfg_    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A steer request reaches the result register after acceptance through eight target wrap
// steps, nine datapath steps and the delivery step; a stop goes straight to delivery.
// One request is in work at a time; the next is taken the cycle after the result is
// registered. A result still held under out_stall holds the next delivery back.
// Synchronous active-low reset clears the sequencer, integrator state and output valid flag,
// and loads the configuration registers with their reset values.
module swerve_steer_pi_servo (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_command,
  input  logic signed [ssps_pkg::TGT_W-1:0]     in_target_angle,
  input  logic [ssps_pkg::CUR_W-1:0]            in_current_angle,
  input  logic [ssps_pkg::TIME_W-1:0]           in_time_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ssps_pkg::PULSE_W-1:0]          out_pulse_us,
  output logic                                  out_reversed,
  output logic                                  out_in_tolerance,
  output logic signed [ssps_pkg::ERR_W-1:0]     out_angle_error,
  output logic signed [ssps_pkg::PI_W-1:0]      out_pi_effort,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ssps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ssps_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [ssps_pkg::PULSE_W-1:0]         neutral_r;
  logic [ssps_pkg::TOL_W-1:0]           tol_r;
  logic [ssps_pkg::GAIN_W-1:0]          kp_r;
  logic signed [ssps_pkg::GAIN_W-1:0]   ki_r;
  ssps_pkg::cmd_t                       cmd;
  ssps_pkg::sts_t                       sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= ssps_pkg::NEUTRAL_RST;
      tol_r     <= ssps_pkg::TOL_RST;
      kp_r      <= ssps_pkg::KP_RST;
      ki_r      <= ssps_pkg::KI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ssps_pkg::cfg_idx_t'(cfg_index))
        ssps_pkg::REG_NEUTRAL: neutral_r <= cfg_data[ssps_pkg::PULSE_W-1:0];
        ssps_pkg::REG_TOL:     tol_r     <= cfg_data[ssps_pkg::TOL_W-1:0];
        ssps_pkg::REG_KP:      kp_r      <= cfg_data;
        ssps_pkg::REG_KI:      ki_r      <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  ssps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  ssps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_target_angle  (in_target_angle),
    .in_current_angle (in_current_angle),
    .in_time_ms       (in_time_ms),
    .neutral_pulse    (neutral_r),
    .tolerance_deg    (tol_r),
    .kp_gain          (kp_r),
    .ki_gain          (ki_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pulse_us     (out_pulse_us),
    .out_reversed     (out_reversed),
    .out_in_tolerance (out_in_tolerance),
    .out_angle_error  (out_angle_error),
    .out_pi_effort    (out_pi_effort)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.deliver)
    else $error("result register overwritten while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in work");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_us >= ssps_pkg::PULSE_W'(ssps_pkg::PULSE_LO)
                   && out_pulse_us <= ssps_pkg::PULSE_W'(ssps_pkg::PULSE_HI)))
    else $error("pulse outside servo range");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_error <= ssps_pkg::FLIP_LIM
                   && out_angle_error >= -ssps_pkg::FLIP_LIM))
    else $error("angle error beyond the turn limit");

endmodule

// File: hw/rtl/ssps_ctrl.sv
// Sequencer of the steering servo: walks one request through the datapath steps.
// Depends on ssps_pkg for the state, command and status types.
module ssps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  input  ssps_pkg::sts_t      sts,
  output ssps_pkg::cmd_t      cmd
);

  ssps_pkg::state_t             state_r, state_nxt;
  logic [ssps_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssps_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.wrap_sh = cnt_r;
    in_stall    = 1'b1;
    unique case (state_r)
      ssps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = ssps_pkg::CNT_W'(ssps_pkg::WRAP_STEPS - 1);
          state_nxt = in_command ? ssps_pkg::ST_DONE : ssps_pkg::ST_WRAP;
        end
      end
      ssps_pkg::ST_WRAP: begin
        cmd.wrap = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ssps_pkg::ST_ERR;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ssps_pkg::ST_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = ssps_pkg::ST_FLIP;
      end
      ssps_pkg::ST_FLIP: begin
        cmd.flip  = 1'b1;
        state_nxt = ssps_pkg::ST_MULA;
      end
      ssps_pkg::ST_MULA: begin
        cmd.mula  = 1'b1;
        state_nxt = ssps_pkg::ST_INTEG;
      end
      ssps_pkg::ST_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = ssps_pkg::ST_MULB;
      end
      ssps_pkg::ST_MULB: begin
        cmd.mulb  = 1'b1;
        state_nxt = ssps_pkg::ST_SUM;
      end
      ssps_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ssps_pkg::ST_DIV;
      end
      ssps_pkg::ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ssps_pkg::ST_POST1;
      end
      ssps_pkg::ST_POST1: begin
        cmd.post1 = 1'b1;
        state_nxt = ssps_pkg::ST_POST2;
      end
      ssps_pkg::ST_POST2: begin
        cmd.post2 = 1'b1;
        state_nxt = ssps_pkg::ST_DONE;
      end
      ssps_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.deliver = 1'b1;
          state_nxt   = ssps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/ssps_dp.sv
// Datapath of the steering servo: angle wrap, PI terms, constant divider, result register.
// Depends on ssps_pkg; steered by ssps_ctrl through cmd_t and reports through sts_t.
module ssps_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssps_pkg::cmd_t                        cmd,
  output ssps_pkg::sts_t                        sts,
  input  logic                                  in_command,
  input  logic signed [ssps_pkg::TGT_W-1:0]     in_target_angle,
  input  logic [ssps_pkg::CUR_W-1:0]            in_current_angle,
  input  logic [ssps_pkg::TIME_W-1:0]           in_time_ms,
  input  logic [ssps_pkg::PULSE_W-1:0]          neutral_pulse,
  input  logic [ssps_pkg::TOL_W-1:0]            tolerance_deg,
  input  logic [ssps_pkg::GAIN_W-1:0]           kp_gain,
  input  logic signed [ssps_pkg::GAIN_W-1:0]    ki_gain,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [ssps_pkg::PULSE_W-1:0]          out_pulse_us,
  output logic                                  out_reversed,
  output logic                                  out_in_tolerance,
  output logic signed [ssps_pkg::ERR_W-1:0]     out_angle_error,
  output logic signed [ssps_pkg::PI_W-1:0]      out_pi_effort
);

  function automatic logic signed [ssps_pkg::ERR_W-1:0] shortest(
    input logic [ssps_pkg::DEG_W-1:0] tgt,
    input logic [ssps_pkg::CUR_W-1:0] cur
  );
    logic signed [ssps_pkg::CUR_W+1:0] d;
    d = $signed((ssps_pkg::CUR_W+2)'(tgt) << ssps_pkg::AFB)
        - $signed((ssps_pkg::CUR_W+2)'(cur));
    if (d > ssps_pkg::TURN_HALF) begin
      d = d - (ssps_pkg::CUR_W+2)'(ssps_pkg::TURN_FULL);
    end else if (d < -ssps_pkg::TURN_HALF) begin
      d = d + (ssps_pkg::CUR_W+2)'(ssps_pkg::TURN_FULL);
    end
    return ssps_pkg::ERR_W'(d);
  endfunction

  logic                                   stop_r;
  logic [ssps_pkg::WRAP_W-1:0]            tgt_r;
  logic [ssps_pkg::CUR_W-1:0]             cur_r;
  logic [ssps_pkg::TIME_W-1:0]            now_r;
  logic signed [ssps_pkg::ERR_W-1:0]      err_r;
  logic                                   rev_r;
  logic [ssps_pkg::DT_W-1:0]              dt_r;
  logic [ssps_pkg::AERR_W-1:0]            aerr_r;
  logic signed [ssps_pkg::PROD_W-1:0]     prod_r;
  logic [ssps_pkg::KP1K_W-1:0]            kp1k_r;
  logic signed [ssps_pkg::ISUM_W-1:0]     isum_r;
  logic [ssps_pkg::TIME_W-1:0]            last_time_r;
  logic [ssps_pkg::DEG_W-1:0]             last_tgt_r;
  logic                                   tv_r;
  logic [ssps_pkg::MINP_W-1:0]            minprod_r;
  logic [ssps_pkg::MIN_W-1:0]             min_r;
  logic signed [ssps_pkg::P1_W-1:0]       p1_r;
  logic signed [ssps_pkg::P2_W-1:0]       p2_r;
  logic                                   neg_r;
  logic [ssps_pkg::MAG_W-1:0]             dvd_r;
  logic                                   ovf_r;
  logic [ssps_pkg::QP_W-1:0]              qprod_r;
  logic signed [ssps_pkg::PI_W-1:0]       pi_r;
  logic signed [ssps_pkg::PI_W-1:0]       off_r;
  logic                                   intol_r;
  logic                                   out_valid_r;
  logic [ssps_pkg::PULSE_W-1:0]           out_pulse_r;
  logic                                   out_rev_r;
  logic                                   out_intol_r;
  logic signed [ssps_pkg::ERR_W-1:0]      out_err_r;
  logic signed [ssps_pkg::PI_W-1:0]       out_pi_r;

  logic [ssps_pkg::DEG_W-1:0]             tgt9;
  logic [ssps_pkg::WRAP_W-1:0]            wrap_sub;
  logic signed [ssps_pkg::ERR_W-1:0]      e0;
  logic [ssps_pkg::TIME_W-1:0]            dtr;
  logic [ssps_pkg::DT_W-1:0]              dt_c;
  logic [ssps_pkg::DEG_W-1:0]             tgt_t;
  logic signed [ssps_pkg::ISUM_W-1:0]     base;
  logic signed [ssps_pkg::PROD_W-1:0]     isum_s;
  logic signed [ssps_pkg::ISUM_W-1:0]     isum_c;
  logic [ssps_pkg::MIN_W:0]               min_c;
  logic signed [ssps_pkg::P1_W-1:0]       acc;
  logic [ssps_pkg::P1_W-1:0]              mag;
  logic [ssps_pkg::MAG_W-1:0]             nq;
  logic [ssps_pkg::PI_W-1:0]              qc;
  logic signed [ssps_pkg::PI_W-1:0]       off_c;
  logic [ssps_pkg::PI_W-1:0]              aoff;
  logic [ssps_pkg::PULSE_W-1:0]           neutral_c;
  logic [ssps_pkg::PI_W-1:0]              rnd;
  logic signed [ssps_pkg::PULSE_W+1:0]    pulse_s;
  logic [ssps_pkg::PULSE_W-1:0]           pulse_c;

  assign tgt9     = tgt_r[ssps_pkg::DEG_W-1:0];
  assign wrap_sub = ssps_pkg::WRAP_W'(ssps_pkg::WRAP_MOD) << cmd.wrap_sh;
  assign e0       = shortest(tgt9, cur_r);
  assign dtr      = now_r - last_time_r;

  always_comb begin
    if (dtr == '0) begin
      dt_c = ssps_pkg::DT_W'(1);
    end else if (dtr > ssps_pkg::TIME_W'(ssps_pkg::DT_MAX)) begin
      dt_c = ssps_pkg::DT_W'(ssps_pkg::DT_MAX);
    end else begin
      dt_c = dtr[ssps_pkg::DT_W-1:0];
    end
  end

  assign tgt_t = (tgt9 >= ssps_pkg::DEG_W'(180)) ? tgt9 - ssps_pkg::DEG_W'(180)
                                                 : tgt9 + ssps_pkg::DEG_W'(180);

  always_comb begin
    base   = (!tv_r || tgt9 != last_tgt_r) ? '0 : isum_r;
    isum_s = ssps_pkg::PROD_W'(base) + prod_r;
    if (aerr_r >= ssps_pkg::AERR_W'(ssps_pkg::INT_WIN)) begin
      isum_c = '0;
    end else if (isum_s > ssps_pkg::INT_LIM) begin
      isum_c = ssps_pkg::ISUM_W'(ssps_pkg::INT_LIM);
    end else if (isum_s < -ssps_pkg::INT_LIM) begin
      isum_c = ssps_pkg::ISUM_W'(-ssps_pkg::INT_LIM);
    end else begin
      isum_c = ssps_pkg::ISUM_W'(isum_s);
    end
  end

  assign min_c = (ssps_pkg::MIN_W+1)'(ssps_pkg::EFF_MIN)
               + (ssps_pkg::MIN_W+1)'(minprod_r >> ssps_pkg::MIN_SH);

  assign acc = p1_r + ssps_pkg::P1_W'(p2_r);
  assign mag = acc[ssps_pkg::P1_W-1] ? ssps_pkg::P1_W'(-acc) : ssps_pkg::P1_W'(acc);

  assign nq = dvd_r >> ssps_pkg::DIV_SH;

  assign qc = ovf_r ? ssps_pkg::PI_W'(ssps_pkg::EFF_LIM)
                    : ssps_pkg::PI_W'(qprod_r >> ssps_pkg::RECIP_SH);

  always_comb begin
    off_c = pi_r;
    if ((off_c > 0 && err_r < 0) || (off_c < 0 && err_r > 0)) begin
      off_c = '0;
    end
    aoff = off_c[ssps_pkg::PI_W-1] ? ssps_pkg::PI_W'(-off_c) : ssps_pkg::PI_W'(off_c);
    if (aoff < ssps_pkg::PI_W'(min_r)) begin
      off_c = (err_r >= 0) ? $signed(ssps_pkg::PI_W'(min_r))
                           : -$signed(ssps_pkg::PI_W'(min_r));
    end
  end

  always_comb begin
    if (neutral_pulse < ssps_pkg::PULSE_W'(ssps_pkg::PULSE_LO)) begin
      neutral_c = ssps_pkg::PULSE_W'(ssps_pkg::PULSE_LO);
    end else if (neutral_pulse > ssps_pkg::PULSE_W'(ssps_pkg::PULSE_HI)) begin
      neutral_c = ssps_pkg::PULSE_W'(ssps_pkg::PULSE_HI);
    end else begin
      neutral_c = neutral_pulse;
    end
  end

  always_comb begin
    rnd = ((off_r[ssps_pkg::PI_W-1] ? ssps_pkg::PI_W'(-off_r) : ssps_pkg::PI_W'(off_r))
          + ssps_pkg::PI_W'(ssps_pkg::ASC / 2)) >> ssps_pkg::AFB;
    pulse_s = $signed((ssps_pkg::PULSE_W+2)'(neutral_c));
    if (off_r < 0) begin
      pulse_s = pulse_s - $signed((ssps_pkg::PULSE_W+2)'(rnd));
    end else begin
      pulse_s = pulse_s + $signed((ssps_pkg::PULSE_W+2)'(rnd));
    end
    if (intol_r) begin
      pulse_c = neutral_c;
    end else if (pulse_s < ssps_pkg::PULSE_LO) begin
      pulse_c = ssps_pkg::PULSE_W'(ssps_pkg::PULSE_LO);
    end else if (pulse_s > ssps_pkg::PULSE_HI) begin
      pulse_c = ssps_pkg::PULSE_W'(ssps_pkg::PULSE_HI);
    end else begin
      pulse_c = ssps_pkg::PULSE_W'(pulse_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r        <= 1'b0;
      isum_r      <= '0;
      last_time_r <= '0;
      last_tgt_r  <= '0;
    end else if (cmd.load && in_command) begin
      tv_r        <= 1'b0;
      isum_r      <= '0;
      last_time_r <= in_time_ms;
    end else if (cmd.integ) begin
      tv_r        <= 1'b1;
      isum_r      <= isum_c;
      last_time_r <= now_r;
      last_tgt_r  <= tgt9;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stop_r <= in_command;
      tgt_r  <= ssps_pkg::WRAP_W'(in_target_angle)
              + ssps_pkg::WRAP_W'(ssps_pkg::WRAP_BIAS);
      cur_r  <= (in_current_angle >= ssps_pkg::CUR_W'(ssps_pkg::TURN_FULL))
              ? in_current_angle - ssps_pkg::CUR_W'(ssps_pkg::TURN_FULL)
              : in_current_angle;
      now_r  <= in_time_ms;
    end
    if (cmd.wrap && tgt_r >= wrap_sub) begin
      tgt_r <= tgt_r - wrap_sub;
    end
    if (cmd.err) begin
      err_r <= e0;
      rev_r <= (e0 > ssps_pkg::FLIP_LIM) || (e0 < -ssps_pkg::FLIP_LIM);
      dt_r  <= dt_c;
    end
    if (cmd.flip && rev_r) begin
      tgt_r <= ssps_pkg::WRAP_W'(tgt_t);
      err_r <= shortest(tgt_t, cur_r);
    end
    if (cmd.mula) begin
      prod_r <= ssps_pkg::PROD_W'(err_r) * ssps_pkg::PROD_W'($signed({1'b0, dt_r}));
      kp1k_r <= ssps_pkg::KP1K_W'(kp_gain) * ssps_pkg::KP1K_W'(ssps_pkg::KP_SCALE);
      aerr_r <= (err_r < 0) ? ssps_pkg::AERR_W'(-err_r) : ssps_pkg::AERR_W'(err_r);
    end
    if (cmd.integ) begin
      minprod_r <= ssps_pkg::MINP_W'(aerr_r) * ssps_pkg::MINP_W'(ssps_pkg::MIN_MUL);
    end
    if (cmd.mulb) begin
      p1_r  <= ssps_pkg::P1_W'($signed({1'b0, kp1k_r})) * ssps_pkg::P1_W'(err_r);
      p2_r  <= ssps_pkg::P2_W'(ki_gain) * ssps_pkg::P2_W'(isum_r);
      min_r <= (min_c > (ssps_pkg::MIN_W+1)'(ssps_pkg::EFF_MAX))
             ? ssps_pkg::MIN_W'(ssps_pkg::EFF_MAX) : ssps_pkg::MIN_W'(min_c);
    end
    if (cmd.sum) begin
      neg_r <= acc[ssps_pkg::P1_W-1];
      dvd_r <= ssps_pkg::MAG_W'(mag) + ssps_pkg::MAG_W'(ssps_pkg::DIV_HALF);
    end
    if (cmd.div) begin
      ovf_r   <= nq >= ssps_pkg::MAG_W'(ssps_pkg::QN_LIM);
      qprod_r <= ssps_pkg::QP_W'(nq[ssps_pkg::QN_W-1:0]) * ssps_pkg::QP_W'(ssps_pkg::RECIP);
    end
    if (cmd.post1) begin
      pi_r <= neg_r ? -$signed(qc) : $signed(qc);
    end
    if (cmd.post2) begin
      off_r   <= off_c;
      intol_r <= aerr_r <= (ssps_pkg::AERR_W'(tolerance_deg) << ssps_pkg::AFB);
    end
    if (cmd.deliver) begin
      if (stop_r) begin
        out_pulse_r <= neutral_c;
        out_rev_r   <= 1'b0;
        out_intol_r <= 1'b0;
        out_err_r   <= '0;
        out_pi_r    <= '0;
      end else begin
        out_pulse_r <= pulse_c;
        out_rev_r   <= rev_r;
        out_intol_r <= intol_r;
        out_err_r   <= err_r;
        out_pi_r    <= pi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy     = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_pulse_us     = out_pulse_r;
  assign out_reversed     = out_rev_r;
  assign out_in_tolerance = out_intol_r;
  assign out_angle_error  = out_err_r;
  assign out_pi_effort    = out_pi_r;

endmodule
